// File: hw/rtl/sha256_pkg.sv
// ---------------------------------------------------------------------------
// sha256_pkg
// Shared types, constants and functions of the SHA-256 hash engine.
// ---------------------------------------------------------------------------
`default_nettype none

package sha256_pkg;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_REM,
    S_PAD80,
    S_PADZ,
    S_PADLEN,
    S_LOAD,
    S_RND,
    S_FIN,
    S_OUT
  } sha_state_t;

  typedef struct packed {
    logic       ins_in;
    logic       ins_rem;
    logic       ins_pad;
    logic       ins_zero;
    logic       wr_len;
    logic       load_work;
    logic       round;
    logic       fin;
    logic       shift_out;
    logic       clear;
    logic [5:0] rnd;
  } sha_cmd_t;

  typedef struct packed {
    logic full;
    logic rem_nz;
    logic pos56;
  } sha_sts_t;

  localparam logic [31:0] PAD_WORD = 32'h8000_0000;
  localparam logic [5:0]  LEN_POS  = 6'd56;
  localparam logic [2:0]  WORD_BYTES = 3'd4;

  function automatic logic [31:0] iv_const(input logic [2:0] idx);
    logic [31:0] v;
    unique case (idx)
      3'd0: v = 32'h6a09e667;
      3'd1: v = 32'hbb67ae85;
      3'd2: v = 32'h3c6ef372;
      3'd3: v = 32'ha54ff53a;
      3'd4: v = 32'h510e527f;
      3'd5: v = 32'h9b05688c;
      3'd6: v = 32'h1f83d9ab;
      3'd7: v = 32'h5be0cd19;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] k_const(input logic [5:0] idx);
    logic [31:0] v;
    unique case (idx)
      6'd0:  v = 32'h428a2f98;  6'd1:  v = 32'h71374491;
      6'd2:  v = 32'hb5c0fbcf;  6'd3:  v = 32'he9b5dba5;
      6'd4:  v = 32'h3956c25b;  6'd5:  v = 32'h59f111f1;
      6'd6:  v = 32'h923f82a4;  6'd7:  v = 32'hab1c5ed5;
      6'd8:  v = 32'hd807aa98;  6'd9:  v = 32'h12835b01;
      6'd10: v = 32'h243185be;  6'd11: v = 32'h550c7dc3;
      6'd12: v = 32'h72be5d74;  6'd13: v = 32'h80deb1fe;
      6'd14: v = 32'h9bdc06a7;  6'd15: v = 32'hc19bf174;
      6'd16: v = 32'he49b69c1;  6'd17: v = 32'hefbe4786;
      6'd18: v = 32'h0fc19dc6;  6'd19: v = 32'h240ca1cc;
      6'd20: v = 32'h2de92c6f;  6'd21: v = 32'h4a7484aa;
      6'd22: v = 32'h5cb0a9dc;  6'd23: v = 32'h76f988da;
      6'd24: v = 32'h983e5152;  6'd25: v = 32'ha831c66d;
      6'd26: v = 32'hb00327c8;  6'd27: v = 32'hbf597fc7;
      6'd28: v = 32'hc6e00bf3;  6'd29: v = 32'hd5a79147;
      6'd30: v = 32'h06ca6351;  6'd31: v = 32'h14292967;
      6'd32: v = 32'h27b70a85;  6'd33: v = 32'h2e1b2138;
      6'd34: v = 32'h4d2c6dfc;  6'd35: v = 32'h53380d13;
      6'd36: v = 32'h650a7354;  6'd37: v = 32'h766a0abb;
      6'd38: v = 32'h81c2c92e;  6'd39: v = 32'h92722c85;
      6'd40: v = 32'ha2bfe8a1;  6'd41: v = 32'ha81a664b;
      6'd42: v = 32'hc24b8b70;  6'd43: v = 32'hc76c51a3;
      6'd44: v = 32'hd192e819;  6'd45: v = 32'hd6990624;
      6'd46: v = 32'hf40e3585;  6'd47: v = 32'h106aa070;
      6'd48: v = 32'h19a4c116;  6'd49: v = 32'h1e376c08;
      6'd50: v = 32'h2748774c;  6'd51: v = 32'h34b0bcb5;
      6'd52: v = 32'h391c0cb3;  6'd53: v = 32'h4ed8aa4a;
      6'd54: v = 32'h5b9cca4f;  6'd55: v = 32'h682e6ff3;
      6'd56: v = 32'h748f82ee;  6'd57: v = 32'h78a5636f;
      6'd58: v = 32'h84c87814;  6'd59: v = 32'h8cc70208;
      6'd60: v = 32'h90befffa;  6'd61: v = 32'ha4506ceb;
      6'd62: v = 32'hbef9a3f7;  6'd63: v = 32'hc67178f2;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] big_s0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_s1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] sm_s0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] sm_s1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/sha256_hash_engine_core.sv
// ---------------------------------------------------------------------------
// sha256_hash_engine_core
// SHA-256 digest engine with a streaming word input and digest output.
// ---------------------------------------------------------------------------
// The message enters on the in_ channel as big-endian 32-bit words. in_tuser
// gives the number of valid leading bytes (values above 4 count as 4) and
// in_tlast marks the final word of the message. A word is accepted directly
// unless it completes a 64-byte block, which is compressed (one load, 64
// rounds through the single round unit, one final add) before another word
// is accepted; the remainder of a word that spills past a block boundary is
// inserted after that compression. After the last word the engine pads one
// zero-fill word per cycle, pausing while a full block is compressed, writes
// the bit length and compresses one or two final blocks. The digest then
// appears on the out_ channel as four 64-bit transfers, most significant
// first, with out_tuser giving the part index and out_tlast on the fourth.
// A stalled receiver holds the current part; no new message is taken until
// the fourth part is transferred, after which the engine starts over from
// the initial hash values. Reset returns the engine to that same state.
// ---------------------------------------------------------------------------
`default_nettype none

module sha256_hash_engine_core
  import sha256_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] data_word
  input  wire logic [2:0]  in_tuser,   // [2:0] valid_bytes
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // [63:0] digest_part
  output logic [1:0]       out_tuser,  // [1:0] part_index
  output logic             out_tlast
);

  sha_cmd_t cmd;
  sha_sts_t sts;

  sha256_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .sts        (sts)
  );

  sha256_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_tdata),
    .in_bytes (in_tuser),
    .cmd      (cmd),
    .sts      (sts),
    .digest   (out_tdata)
  );

endmodule

`default_nettype wire

// File: hw/rtl/sha256_ctrl.sv
// ---------------------------------------------------------------------------
// sha256_ctrl
// Sequencer for word intake, padding, compression rounds and digest output.
// ---------------------------------------------------------------------------
`default_nettype none

module sha256_ctrl
  import sha256_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_tvalid,
  output logic          in_tready,
  input  wire logic     in_tlast,
  output logic          out_tvalid,
  input  wire logic     out_tready,
  output logic [1:0]    out_tuser,
  output logic          out_tlast,
  output sha_cmd_t      cmd,
  input  wire sha_sts_t sts
);

  sha_state_t st_r, st_nxt;
  sha_state_t ret_r, ret_nxt;
  logic [5:0] rnd_r, rnd_nxt;
  logic [1:0] part_r, part_nxt;
  logic       last_r, last_nxt;
  sha_state_t tgt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      ret_r  <= S_IDLE;
      rnd_r  <= '0;
      part_r <= '0;
      last_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      ret_r  <= ret_nxt;
      rnd_r  <= rnd_nxt;
      part_r <= part_nxt;
      last_r <= last_nxt;
    end
  end

  always_comb begin
    st_nxt     = st_r;
    ret_nxt    = ret_r;
    rnd_nxt    = rnd_r;
    part_nxt   = part_r;
    last_nxt   = last_r;
    cmd        = '0;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    tgt        = S_IDLE;
    unique case (st_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.ins_in = 1'b1;
          last_nxt   = in_tlast;
          tgt = sts.rem_nz ? S_INS_REM : (in_tlast ? S_PAD80 : S_IDLE);
          if (sts.full) begin
            st_nxt  = S_LOAD;
            ret_nxt = tgt;
          end else begin
            st_nxt = tgt;
          end
        end
      end
      S_INS_REM: begin
        cmd.ins_rem = 1'b1;
        st_nxt = last_r ? S_PAD80 : S_IDLE;
      end
      S_PAD80: begin
        cmd.ins_pad = 1'b1;
        if (sts.full) begin
          st_nxt  = S_LOAD;
          ret_nxt = S_PADZ;
        end else begin
          st_nxt = S_PADZ;
        end
      end
      S_PADZ: begin
        if (sts.pos56) begin
          st_nxt = S_PADLEN;
        end else begin
          cmd.ins_zero = 1'b1;
          if (sts.full) begin
            st_nxt  = S_LOAD;
            ret_nxt = S_PADZ;
          end
        end
      end
      S_PADLEN: begin
        cmd.wr_len = 1'b1;
        st_nxt     = S_LOAD;
        ret_nxt    = S_OUT;
        part_nxt   = '0;
      end
      S_LOAD: begin
        cmd.load_work = 1'b1;
        rnd_nxt       = '0;
        st_nxt        = S_RND;
      end
      S_RND: begin
        cmd.round = 1'b1;
        cmd.rnd   = rnd_r;
        rnd_nxt   = rnd_r + 6'd1;
        if (rnd_r == 6'd63) begin
          st_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.fin = 1'b1;
        st_nxt  = ret_r;
      end
      S_OUT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          if (part_r == 2'd3) begin
            cmd.clear = 1'b1;
            part_nxt  = '0;
            st_nxt    = S_IDLE;
          end else begin
            cmd.shift_out = 1'b1;
            part_nxt      = part_r + 2'd1;
          end
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  assign out_tuser = part_r;
  assign out_tlast = (part_r == 2'd3);

endmodule

`default_nettype wire

// File: hw/rtl/sha256_dp.sv
// ---------------------------------------------------------------------------
// sha256_dp
// Block buffer with byte insertion, message schedule, round unit,
// chaining words and byte counter.
// ---------------------------------------------------------------------------
`default_nettype none

module sha256_dp
  import sha256_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [31:0] in_word,
  input  wire logic [2:0]  in_bytes,
  input  wire sha_cmd_t    cmd,
  output sha_sts_t         sts,
  output logic [63:0]      digest
);

  logic [31:0] blk_r   [16];
  logic [31:0] blk_nxt [16];
  logic [31:0] chain_r   [8];
  logic [31:0] chain_nxt [8];
  logic [31:0] wv_r   [8];
  logic [31:0] wv_nxt [8];
  logic [60:0] cnt_r, cnt_nxt;
  logic [5:0]  pos_r, pos_nxt;
  logic [31:0] rem_word_r, rem_word_nxt;
  logic [2:0]  rem_n_r, rem_n_nxt;

  logic [2:0]  in_n;
  logic [31:0] src;
  logic [2:0]  n;
  logic        ins;
  logic [1:0]  off;
  logic [3:0]  wi;
  logic [6:0]  room;
  logic [2:0]  fit;
  logic [6:0]  sum;
  logic [3:0]  m4;
  logic [7:0]  m8;
  logic [63:0] wide;
  logic [63:0] bit_len;
  logic [31:0] t1, t2, w_new;

  function automatic logic [31:0] merge(input logic [31:0] old, input logic [31:0] nw,
                                        input logic [3:0] m);
    logic [31:0] r;
    r = old;
    for (int b = 0; b < 4; b++) begin
      if (m[b]) begin
        r[8*b +: 8] = nw[8*b +: 8];
      end
    end
    return r;
  endfunction

  assign in_n = (in_bytes > WORD_BYTES) ? WORD_BYTES : in_bytes;
  assign off  = pos_r[1:0];
  assign wi   = pos_r[5:2];

  always_comb begin
    src = '0;
    n   = '0;
    priority if (cmd.ins_in) begin
      src = in_word;
      n   = in_n;
    end else if (cmd.ins_rem) begin
      src = rem_word_r;
      n   = rem_n_r;
    end else if (cmd.ins_pad) begin
      src = PAD_WORD;
      n   = 3'd1;
    end else if (cmd.ins_zero) begin
      src = '0;
      n   = WORD_BYTES - {1'b0, off};
    end else begin
      src = '0;
      n   = '0;
    end
  end

  assign ins  = cmd.ins_in | cmd.ins_rem | cmd.ins_pad | cmd.ins_zero;
  assign room = 7'd64 - {1'b0, pos_r};
  assign fit  = ({4'b0, n} < room) ? n : room[2:0];
  assign sum  = {1'b0, pos_r} + {4'b0, fit};
  assign m4   = ~(4'b1111 >> fit);
  assign m8   = {m4, 4'b0} >> off;
  assign wide = {src, 32'b0} >> {off, 3'b0};

  assign sts.full   = ins & sum[6];
  assign sts.rem_nz = (n != fit);
  assign sts.pos56  = (pos_r == LEN_POS);

  assign bit_len = {cnt_r, 3'b000};
  assign digest  = {chain_r[0], chain_r[1]};

  assign t1 = wv_r[7] + big_s1(wv_r[4]) + ((wv_r[4] & wv_r[5]) ^ (~wv_r[4] & wv_r[6]))
            + k_const(cmd.rnd) + blk_r[0];
  assign t2 = big_s0(wv_r[0])
            + ((wv_r[0] & wv_r[1]) ^ (wv_r[0] & wv_r[2]) ^ (wv_r[1] & wv_r[2]));
  assign w_new = blk_r[0] + sm_s0(blk_r[1]) + blk_r[9] + sm_s1(blk_r[14]);

  always_comb begin
    blk_nxt      = blk_r;
    chain_nxt    = chain_r;
    wv_nxt       = wv_r;
    cnt_nxt      = cnt_r;
    pos_nxt      = pos_r;
    rem_word_nxt = rem_word_r;
    rem_n_nxt    = rem_n_r;
    if (ins) begin
      for (int j = 0; j < 16; j++) begin
        if (4'(j) == wi) begin
          blk_nxt[j] = merge(blk_r[j], wide[63:32], m8[7:4]);
        end else if (4'(j) == wi + 4'd1) begin
          blk_nxt[j] = merge(blk_r[j], wide[31:0], m8[3:0]);
        end
      end
      pos_nxt      = sum[5:0];
      rem_word_nxt = src << {fit, 3'b000};
      rem_n_nxt    = n - fit;
    end
    if (cmd.ins_in) begin
      cnt_nxt = cnt_r + {58'b0, in_n};
    end
    if (cmd.wr_len) begin
      blk_nxt[14] = bit_len[63:32];
      blk_nxt[15] = bit_len[31:0];
    end
    if (cmd.load_work) begin
      wv_nxt = chain_r;
    end
    if (cmd.round) begin
      for (int j = 0; j < 15; j++) begin
        blk_nxt[j] = blk_r[j+1];
      end
      blk_nxt[15] = w_new;
      wv_nxt[7] = wv_r[6];
      wv_nxt[6] = wv_r[5];
      wv_nxt[5] = wv_r[4];
      wv_nxt[4] = wv_r[3] + t1;
      wv_nxt[3] = wv_r[2];
      wv_nxt[2] = wv_r[1];
      wv_nxt[1] = wv_r[0];
      wv_nxt[0] = t1 + t2;
    end
    if (cmd.fin) begin
      for (int j = 0; j < 8; j++) begin
        chain_nxt[j] = chain_r[j] + wv_r[j];
      end
      pos_nxt = '0;
    end
    if (cmd.shift_out) begin
      for (int j = 0; j < 6; j++) begin
        chain_nxt[j] = chain_r[j+2];
      end
    end
    if (cmd.clear) begin
      for (int j = 0; j < 8; j++) begin
        chain_nxt[j] = iv_const(3'(j));
      end
      cnt_nxt = '0;
      pos_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < 8; j++) begin
        chain_r[j] <= iv_const(3'(j));
      end
      cnt_r <= '0;
      pos_r <= '0;
    end else begin
      chain_r <= chain_nxt;
      cnt_r   <= cnt_nxt;
      pos_r   <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    blk_r      <= blk_nxt;
    wv_r       <= wv_nxt;
    rem_word_r <= rem_word_nxt;
    rem_n_r    <= rem_n_nxt;
  end

endmodule

`default_nettype wire
